@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker file of this project.
// Depends on nothing; included by the files that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising edge of clk, off while reset is low.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked on every rising edge of clk, off while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ rtl/core/sm4_pkg.sv @@
// Types, constants and functions of the SM4 cipher block.
// Depends on nothing; used by sm4_cell, sm4_block_cipher and the bench.
package sm4_pkg;

  localparam int unsigned NumRounds = 32;
  localparam int unsigned RndW = 5;

  typedef logic [31:0] word_t;
  typedef logic [RndW-1:0] rnd_t;

  typedef enum logic [1:0] {
    CFG_KEY_HIGH = 2'd0,
    CFG_KEY_LOW = 2'd1,
    CFG_DECRYPT_MODE = 2'd2
  } cfg_idx_t;

  // Control passed from the sequencer to every round cell.
  typedef struct packed {
    logic load;
    logic step;
    logic key_mode;
  } cell_ctrl_t;

  localparam word_t Fk0 = 32'ha3b1bac6;
  localparam word_t Fk1 = 32'h56aa3350;
  localparam word_t Fk2 = 32'h677d9197;
  localparam word_t Fk3 = 32'hb27022dc;

  localparam logic [7:0] Sbox [256] = '{
    8'hd6, 8'h90, 8'he9, 8'hfe, 8'hcc, 8'he1, 8'h3d, 8'hb7,
    8'h16, 8'hb6, 8'h14, 8'hc2, 8'h28, 8'hfb, 8'h2c, 8'h05,
    8'h2b, 8'h67, 8'h9a, 8'h76, 8'h2a, 8'hbe, 8'h04, 8'hc3,
    8'haa, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
    8'h9c, 8'h42, 8'h50, 8'hf4, 8'h91, 8'hef, 8'h98, 8'h7a,
    8'h33, 8'h54, 8'h0b, 8'h43, 8'hed, 8'hcf, 8'hac, 8'h62,
    8'he4, 8'hb3, 8'h1c, 8'ha9, 8'hc9, 8'h08, 8'he8, 8'h95,
    8'h80, 8'hdf, 8'h94, 8'hfa, 8'h75, 8'h8f, 8'h3f, 8'ha6,
    8'h47, 8'h07, 8'ha7, 8'hfc, 8'hf3, 8'h73, 8'h17, 8'hba,
    8'h83, 8'h59, 8'h3c, 8'h19, 8'he6, 8'h85, 8'h4f, 8'ha8,
    8'h68, 8'h6b, 8'h81, 8'hb2, 8'h71, 8'h64, 8'hda, 8'h8b,
    8'hf8, 8'heb, 8'h0f, 8'h4b, 8'h70, 8'h56, 8'h9d, 8'h35,
    8'h1e, 8'h24, 8'h0e, 8'h5e, 8'h63, 8'h58, 8'hd1, 8'ha2,
    8'h25, 8'h22, 8'h7c, 8'h3b, 8'h01, 8'h21, 8'h78, 8'h87,
    8'hd4, 8'h00, 8'h46, 8'h57, 8'h9f, 8'hd3, 8'h27, 8'h52,
    8'h4c, 8'h36, 8'h02, 8'he7, 8'ha0, 8'hc4, 8'hc8, 8'h9e,
    8'hea, 8'hbf, 8'h8a, 8'hd2, 8'h40, 8'hc7, 8'h38, 8'hb5,
    8'ha3, 8'hf7, 8'hf2, 8'hce, 8'hf9, 8'h61, 8'h15, 8'ha1,
    8'he0, 8'hae, 8'h5d, 8'ha4, 8'h9b, 8'h34, 8'h1a, 8'h55,
    8'had, 8'h93, 8'h32, 8'h30, 8'hf5, 8'h8c, 8'hb1, 8'he3,
    8'h1d, 8'hf6, 8'he2, 8'h2e, 8'h82, 8'h66, 8'hca, 8'h60,
    8'hc0, 8'h29, 8'h23, 8'hab, 8'h0d, 8'h53, 8'h4e, 8'h6f,
    8'hd5, 8'hdb, 8'h37, 8'h45, 8'hde, 8'hfd, 8'h8e, 8'h2f,
    8'h03, 8'hff, 8'h6a, 8'h72, 8'h6d, 8'h6c, 8'h5b, 8'h51,
    8'h8d, 8'h1b, 8'haf, 8'h92, 8'hbb, 8'hdd, 8'hbc, 8'h7f,
    8'h11, 8'hd9, 8'h5c, 8'h41, 8'h1f, 8'h10, 8'h5a, 8'hd8,
    8'h0a, 8'hc1, 8'h31, 8'h88, 8'ha5, 8'hcd, 8'h7b, 8'hbd,
    8'h2d, 8'h74, 8'hd0, 8'h12, 8'hb8, 8'he5, 8'hb4, 8'hb0,
    8'h89, 8'h69, 8'h97, 8'h4a, 8'h0c, 8'h96, 8'h77, 8'h7e,
    8'h65, 8'hb9, 8'hf1, 8'h09, 8'hc5, 8'h6e, 8'hc6, 8'h84,
    8'h18, 8'hf0, 8'h7d, 8'hec, 8'h3a, 8'hdc, 8'h4d, 8'h20,
    8'h79, 8'hee, 8'h5f, 8'h3e, 8'hd7, 8'hcb, 8'h39, 8'h48
  };

  // CK[i] byte j is (4i + j) * 7 mod 256.
  function automatic word_t chain_const(input rnd_t idx);
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    b0 = 8'({idx, 2'd0} * 7);
    b1 = 8'({idx, 2'd1} * 7);
    b2 = 8'({idx, 2'd2} * 7);
    b3 = 8'({idx, 2'd3} * 7);
    return {b0, b1, b2, b3};
  endfunction

  function automatic word_t sub_word(input word_t a);
    return {Sbox[a[31:24]], Sbox[a[23:16]], Sbox[a[15:8]], Sbox[a[7:0]]};
  endfunction

  function automatic word_t rotl(input word_t v, input int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

endpackage

@@ rtl/core/sm4_if.sv @@
// Valid/ready channel interfaces for the SM4 block: data items and register writes.
// Depends on nothing.
interface sm4_data_if;
  logic valid;
  logic ready;
  logic [63:0] high;
  logic [63:0] low;
  modport source (output valid, output high, output low, input ready);
  modport sink (input valid, input high, input low, output ready);
endinterface

interface sm4_cfg_if;
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [63:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/sm4_ram.sv @@
// Generic single-port RAM with registered read, used for the round key store.
// Depends on nothing.
module sm4_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

@@ rtl/core/sm4_cell.sv @@
// One SM4 word cell of the four-cell chain; the last cell computes the round function.
// Depends on sm4_pkg.
module sm4_cell #(
  parameter bit Last = 1'b0
) (
  input  logic                clk,
  input  sm4_pkg::cell_ctrl_t ctrl,
  input  sm4_pkg::word_t      load_word,
  input  sm4_pkg::word_t      chain_in,
  input  sm4_pkg::word_t      head_word,
  input  sm4_pkg::word_t      mix_in,
  input  sm4_pkg::word_t      round_key,
  output sm4_pkg::word_t      word_out
);
  sm4_pkg::word_t word_r;
  sm4_pkg::word_t word_nxt;
  sm4_pkg::word_t sb;
  sm4_pkg::word_t lin;

  // mix_in is the xor of words w[1], w[2] and w[3]; the last cell closes the round.
  always_comb begin
    sb = sm4_pkg::sub_word(mix_in ^ round_key);
    if (ctrl.key_mode) begin
      lin = sb ^ sm4_pkg::rotl(sb, 13) ^ sm4_pkg::rotl(sb, 23);
    end else begin
      lin = sb ^ sm4_pkg::rotl(sb, 2) ^ sm4_pkg::rotl(sb, 10)
          ^ sm4_pkg::rotl(sb, 18) ^ sm4_pkg::rotl(sb, 24);
    end
    word_nxt = word_r;
    if (ctrl.load) begin
      word_nxt = load_word;
    end else if (ctrl.step) begin
      word_nxt = Last ? (head_word ^ lin) : chain_in;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word_out = word_r;
endmodule

@@ rtl/core/sm4_block_cipher.sv @@
// SM4 block cipher top level: one round a cycle through a chain of four word cells.
// Each item is loaded, its first round key is read, then the rounds run and the result is
// registered for output; only then is a new item accepted, so items do not overlap.
// Key expansion runs after any key write and before the next item is processed.
// Reset (rst_n, synchronous, active low) clears keys, mode and control state.
// Depends on sm4_pkg, sm4_if, sm4_ram and sm4_cell.
module sm4_block_cipher (
  input logic clk,
  input logic rst_n,
  sm4_data_if.sink in_ch,
  sm4_data_if.source out_ch,
  sm4_cfg_if.sink cfg_ch
);
  typedef enum logic [2:0] {
    ST_IDLE, ST_KLOAD, ST_KEXP, ST_DPRE, ST_DLOAD, ST_DRUN, ST_OUT
  } state_t;

  state_t state_r;
  sm4_pkg::rnd_t cnt_r;
  logic keys_ready_r;
  logic decrypt_r;
  logic [63:0] key_high_r;
  logic [63:0] key_low_r;
  logic [63:0] blk_high_r;
  logic [63:0] blk_low_r;
  logic out_valid_r;
  logic [63:0] res_high_r;
  logic [63:0] res_low_r;

  sm4_pkg::cell_ctrl_t ctrl;
  sm4_pkg::word_t w [4];
  sm4_pkg::word_t ld [4];
  sm4_pkg::word_t mix;
  sm4_pkg::word_t rk;
  sm4_pkg::word_t ram_q;
  sm4_pkg::rnd_t ram_addr;
  sm4_pkg::rnd_t next_cnt;
  logic ram_we;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.high = res_high_r;
  assign out_ch.low = res_low_r;

  assign next_cnt = cnt_r + 1'b1;

  always_comb begin
    ctrl.load = 1'b0;
    ctrl.step = 1'b0;
    ctrl.key_mode = 1'b0;
    ld[0] = blk_high_r[63:32];
    ld[1] = blk_high_r[31:0];
    ld[2] = blk_low_r[63:32];
    ld[3] = blk_low_r[31:0];
    rk = ram_q;
    case (state_r)
      ST_KLOAD: begin
        ctrl.load = 1'b1;
        ld[0] = key_high_r[63:32] ^ sm4_pkg::Fk0;
        ld[1] = key_high_r[31:0] ^ sm4_pkg::Fk1;
        ld[2] = key_low_r[63:32] ^ sm4_pkg::Fk2;
        ld[3] = key_low_r[31:0] ^ sm4_pkg::Fk3;
      end
      ST_KEXP: begin
        ctrl.step = 1'b1;
        ctrl.key_mode = 1'b1;
        rk = sm4_pkg::chain_const(cnt_r);
      end
      ST_DLOAD: ctrl.load = 1'b1;
      ST_DRUN: ctrl.step = 1'b1;
      default: ;
    endcase
  end

  // The store is written in the cycle after each key round, when the new word sits in cell 3.
  logic kwr_r;
  sm4_pkg::rnd_t kaddr_r;
  assign ram_we = kwr_r;
  always_comb begin
    if (kwr_r) begin
      ram_addr = kaddr_r;
    end else begin
      // Address of the key for the next round; the read is registered.
      ram_addr = (state_r == ST_DPRE) ? 5'd0 : next_cnt;
      if (state_r == ST_DLOAD) begin
        ram_addr = 5'd0;
      end
      if (decrypt_r) begin
        ram_addr = ~ram_addr;
      end
    end
  end

  assign mix = w[1] ^ w[2] ^ w[3];

  sm4_ram #(.Width(32), .Depth(sm4_pkg::NumRounds)) u_rk (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(w[3]), .rdata(ram_q)
  );

  for (genvar g = 0; g < 4; g++) begin : g_cell
    sm4_cell #(.Last(g == 3)) u_cell (
      .clk(clk), .ctrl(ctrl), .load_word(ld[g]),
      .chain_in((g == 3) ? w[0] : w[(g + 1) % 4]),
      .head_word(w[0]), .mix_in(mix), .round_key(rk), .word_out(w[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r <= '0;
      keys_ready_r <= 1'b0;
      decrypt_r <= 1'b0;
      key_high_r <= '0;
      key_low_r <= '0;
      out_valid_r <= 1'b0;
      kwr_r <= 1'b0;
      kaddr_r <= '0;
    end else begin
      kwr_r <= (state_r == ST_KEXP);
      kaddr_r <= cnt_r;
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          sm4_pkg::CFG_KEY_HIGH: begin
            key_high_r <= cfg_ch.data;
            keys_ready_r <= 1'b0;
          end
          sm4_pkg::CFG_KEY_LOW: begin
            key_low_r <= cfg_ch.data;
            keys_ready_r <= 1'b0;
          end
          sm4_pkg::CFG_DECRYPT_MODE: decrypt_r <= cfg_ch.data[0];
          default: ;
        endcase
      end
      if (out_valid_r && out_ch.ready && (state_r != ST_OUT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_ch.valid) begin
            blk_high_r <= in_ch.high;
            blk_low_r <= in_ch.low;
            state_r <= keys_ready_r ? ST_DPRE : ST_KLOAD;
          end
        end
        ST_KLOAD: begin
          cnt_r <= '0;
          state_r <= ST_KEXP;
        end
        ST_KEXP: begin
          cnt_r <= next_cnt;
          if (cnt_r == 5'd31) begin
            keys_ready_r <= 1'b1;
            state_r <= ST_DPRE;
          end
        end
        ST_DPRE: begin
          // Waits out the last key write; the first key is read here when no write is due, and again in ST_DLOAD.
          cnt_r <= '0;
          state_r <= ST_DLOAD;
        end
        ST_DLOAD: state_r <= ST_DRUN;
        ST_DRUN: begin
          cnt_r <= next_cnt;
          if (cnt_r == 5'd31) begin
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            res_high_r <= {w[3], w[2]};
            res_low_r <= {w[1], w[0]};
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end
endmodule

@@ rtl/core/sm4_checker.sv @@
// Port-level checker for sm4_block_cipher, attached by the bind at the end.
// Depends on assert_macros.svh, sm4_if and sm4_block_cipher (the bind target).
`include "assert_macros.svh"
module sm4_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [63:0] out_high
);
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_high), "result item dropped while stalled")
  `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready, "second item accepted while busy")
  `ASSERT_NEXT(a_no_out_soon, clk, rst_n, in_valid && in_ready, !$rose(out_valid), "result item too early")
endmodule

bind sm4_block_cipher sm4_checker u_sm4_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_high(out_ch.high)
);

@@ bench/tb_if.sv @@
// Bench-side note: the channel interfaces come from the RTL file sm4_if.sv.
// This file holds a small package of stimulus records used by tb_top.
// Depends on sm4_pkg.
package tb_sm4_pkg;

  typedef struct packed {
    logic [63:0] high;
    logic [63:0] low;
  } block_t;

  typedef struct packed {
    sm4_pkg::cfg_idx_t idx;
    logic [63:0]       data;
  } reg_write_t;
endpackage

@@ bench/tb_top.sv @@
// Self-checking bench for the SM4 block cipher: random and directed blocks under
// several keys and both directions, checked against an in-bench cipher model.
// Depends on sm4_pkg, sm4_if, tb_sm4_pkg and the sm4_block_cipher RTL.
module tb_top;

  localparam int LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  sm4_data_if in_if ();
  sm4_data_if out_if ();
  sm4_cfg_if cfg_if ();

  sm4_block_cipher u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if.sink), .out_ch(out_if.source), .cfg_ch(cfg_if.sink)
  );

  logic [7:0] sbox_tbl [256];
  logic [31:0] rk [32];
  logic [63:0] key_hi_m, key_lo_m;
  logic dec_m;
  logic keys_valid;

  tb_sm4_pkg::block_t pending_blocks[$];
  tb_sm4_pkg::block_t expected_blocks[$];
  int errors = 0;
  int idle_cycles = 0;
  bit no_gaps = 0;
  bit hold_long = 0;
  bit in_busy = 0;

  function automatic logic [31:0] subw(input logic [31:0] a);
    return {sbox_tbl[a[31:24]], sbox_tbl[a[23:16]], sbox_tbl[a[15:8]], sbox_tbl[a[7:0]]};
  endfunction

  function automatic logic [31:0] rl(input logic [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  task automatic expand_round_keys();
    logic [31:0] k [4];
    logic [31:0] b, nk, ck;
    int i;
    k[0] = key_hi_m[63:32] ^ 32'ha3b1bac6;
    k[1] = key_hi_m[31:0] ^ 32'h56aa3350;
    k[2] = key_lo_m[63:32] ^ 32'h677d9197;
    k[3] = key_lo_m[31:0] ^ 32'hb27022dc;
    for (i = 0; i < 32; i++) begin
      ck = {8'((4*i)*7), 8'((4*i+1)*7), 8'((4*i+2)*7), 8'((4*i+3)*7)};
      b = subw(k[1] ^ k[2] ^ k[3] ^ ck);
      nk = k[0] ^ b ^ rl(b, 13) ^ rl(b, 23);
      k[0] = k[1]; k[1] = k[2]; k[2] = k[3]; k[3] = nk;
      rk[i] = nk;
    end
    keys_valid = 1'b1;
  endtask

  task automatic predict_cipher(input tb_sm4_pkg::block_t blk);
    logic [31:0] w [4];
    logic [31:0] b, nw;
    tb_sm4_pkg::block_t res;
    int r;
    if (!keys_valid) expand_round_keys();
    w[0] = blk.high[63:32]; w[1] = blk.high[31:0];
    w[2] = blk.low[63:32];  w[3] = blk.low[31:0];
    for (r = 0; r < 32; r++) begin
      b = subw(w[1] ^ w[2] ^ w[3] ^ rk[dec_m ? 31 - r : r]);
      nw = w[0] ^ b ^ rl(b, 2) ^ rl(b, 10) ^ rl(b, 18) ^ rl(b, 24);
      w[0] = w[1]; w[1] = w[2]; w[2] = w[3]; w[3] = nw;
    end
    res.high = {w[3], w[2]};
    res.low = {w[1], w[0]};
    expected_blocks.insert(expected_blocks.size(), res);
  endtask

  // Input driver: bursts of idle cycles, none once no_gaps is set.
  int in_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.high <= '0;
      in_if.low <= '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        predict_cipher('{in_if.high, in_if.low});
        void'(pending_blocks.pop_front());
      end
      if (in_gap > 0) begin
        in_gap--;
        in_if.valid <= 1'b0;
      end else if ((!in_if.valid || in_if.ready) && !no_gaps && $urandom_range(0, 9) == 0) begin
        in_gap = $urandom_range(1, 19);
        in_if.valid <= 1'b0;
      end else if (in_if.valid && !in_if.ready) begin
        // hold the offered item
      end else if (pending_blocks.size() > 0 && in_busy) begin
        in_if.valid <= 1'b1;
        in_if.high <= pending_blocks[0].high;
        in_if.low <= pending_blocks[0].low;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Output monitor and receiver stall.
  int out_gap = 0;
  int hold_cnt = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_blocks.size() == 0) begin
          errors++;
          $display("%0t unexpected result %h %h", $time, out_if.high, out_if.low);
        end else begin
          if (out_if.high !== expected_blocks[0].high) begin
            errors++;
            $display("%0t result_high expected %h actual %h", $time,
                     expected_blocks[0].high, out_if.high);
          end
          if (out_if.low !== expected_blocks[0].low) begin
            errors++;
            $display("%0t result_low expected %h actual %h", $time,
                     expected_blocks[0].low, out_if.low);
          end
          void'(expected_blocks.pop_front());
        end
      end
      if (hold_long && hold_cnt < 300) begin
        hold_cnt++;
        out_if.ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_if.ready <= 1'b0;
      end else if (!no_gaps && $urandom_range(0, 9) == 0) begin
        out_gap = $urandom_range(1, 19);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any accepted item or register write.
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
        || (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input sm4_pkg::cfg_idx_t idx, input logic [63:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    case (idx)
      sm4_pkg::CFG_KEY_HIGH: begin key_hi_m = val; keys_valid = 1'b0; end
      sm4_pkg::CFG_KEY_LOW: begin key_lo_m = val; keys_valid = 1'b0; end
      sm4_pkg::CFG_DECRYPT_MODE: dec_m = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic run_blocks(input int n);
    tb_sm4_pkg::block_t b;
    int i;
    for (i = 0; i < n; i++) begin
      b.high = {$urandom, $urandom};
      b.low = {$urandom, $urandom};
      pending_blocks.insert(pending_blocks.size(), b);
    end
    in_busy = 1;
    while (pending_blocks.size() > 0 || in_if.valid) @(posedge clk);
    in_busy = 0;
    while (expected_blocks.size() > 0) @(posedge clk);
    // Idle spell before the next register write; key expansion only starts with the next item.
    repeat (80) @(posedge clk);
  endtask

  initial begin
    int p;
    tb_sm4_pkg::block_t b;
    sbox_tbl = sm4_pkg::Sbox;
    key_hi_m = '0; key_lo_m = '0; dec_m = 1'b0; keys_valid = 1'b0;
    cfg_if.valid = 1'b0; cfg_if.index = sm4_pkg::CFG_KEY_HIGH; cfg_if.data = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Blocks under the reset key, before any register write.
    b = '{64'h0, 64'h0}; pending_blocks.insert(pending_blocks.size(), b);
    b = '{'1, '1}; pending_blocks.insert(pending_blocks.size(), b);
    run_blocks(2);

    // Standard test vector key and block, an end-bits block and an alternating-bit block.
    write_reg(sm4_pkg::CFG_KEY_HIGH, 64'h0123456789abcdef);
    write_reg(sm4_pkg::CFG_KEY_LOW, 64'hfedcba9876543210);
    b = '{64'h0123456789abcdef, 64'hfedcba9876543210};
    pending_blocks.insert(pending_blocks.size(), b);
    b = '{64'h8000000000000000, 64'h1}; pending_blocks.insert(pending_blocks.size(), b);
    b = '{64'h5555555555555555, 64'haaaaaaaaaaaaaaaa};
    pending_blocks.insert(pending_blocks.size(), b);
    run_blocks(3);
    // Mode change alone needs no new expansion.
    write_reg(sm4_pkg::CFG_DECRYPT_MODE, 64'h1);
    b = '{64'h681edf34d206965e, 64'h86b3e94f536e4246};
    pending_blocks.insert(pending_blocks.size(), b);
    run_blocks(4);
    write_reg(sm4_pkg::CFG_KEY_HIGH, '1);
    write_reg(sm4_pkg::CFG_KEY_LOW, '1);
    run_blocks(6);
    write_reg(sm4_pkg::CFG_DECRYPT_MODE, 64'h0);
    run_blocks(6);

    // Random phases with fresh keys (low key kept when p % 3 is 1) and modes.
    for (p = 0; p < 9; p++) begin
      if (p == 2) hold_long = 1;
      if (p == 8) no_gaps = 1;
      write_reg(sm4_pkg::CFG_KEY_HIGH, {$urandom, $urandom});
      if (p % 3 != 1) write_reg(sm4_pkg::CFG_KEY_LOW, {$urandom, $urandom});
      write_reg(sm4_pkg::CFG_DECRYPT_MODE, {63'h0, 1'($urandom)});
      run_blocks(100);
    end

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
